// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is active
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/poly_pkg.sv -----
// ----------------------------------------------------------------------------
// poly_pkg
// Types and constants shared by the polynomial evaluator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package poly_pkg;

  localparam int MAX_DEGREE = 6;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int NUM_COEFFS = MAX_DEGREE + 1;
  localparam int DEG_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int COEFF_IDX_W = $clog2(NUM_COEFFS);

  // Entry register plus two registers per Horner step
  localparam int LATENCY = 2 * MAX_DEGREE + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_LO = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_HI = CFG_IDX_W'(NUM_COEFFS);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] coeff_t;
  typedef coeff_t [NUM_COEFFS-1:0] coeff_vec_t;

  // One evaluation travelling down the pipeline
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] acc;
    logic                     ovf;
  } lane_t;

endpackage

`default_nettype wire

// ----- design/poly_cfg.sv -----
// ----------------------------------------------------------------------------
// poly_cfg
// Configuration registers: degree and coefficients, with degree clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [poly_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [poly_pkg::DATA_W-1:0]    cfg_data,
  output logic [poly_pkg::DEG_W-1:0]          degree,
  output poly_pkg::coeff_vec_t                coeffs
);
  import poly_pkg::*;

  logic [DEG_W-1:0] degree_r;
  coeff_vec_t       coeff_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      coeff_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index) inside
        REG_DEGREE: begin
          degree_r <= cfg_data[DEG_W-1:0];
        end
        [REG_COEFF_LO:REG_COEFF_HI]: begin
          coeff_r[COEFF_IDX_W'(cfg_index - REG_COEFF_LO)] <= cfg_data;
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Clamp degrees beyond the top coefficient
  assign degree = (degree_r > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_r;
  assign coeffs = coeff_r;

endmodule

`default_nettype wire

// ----- design/poly_step.sv -----
// ----------------------------------------------------------------------------
// poly_step
// One Horner step in two register stages: multiply, then shift, saturate,
// add the coefficient and saturate again; inactive steps pass acc through.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 active_i,
  input  wire poly_pkg::coeff_t     coeff_i,
  input  wire poly_pkg::lane_t      lane_i,
  output poly_pkg::lane_t           lane_o
);
  import poly_pkg::*;

  lane_t                    mul_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  lane_t                    out_r;
  lane_t                    out_nxt;

  logic signed [PROD_W-1:0] shifted;
  logic                     mul_sat;
  logic signed [DATA_W-1:0] term;
  logic signed [DATA_W:0]   sum;
  logic                     add_sat;

  assign prod_nxt = $signed(lane_i.acc) * $signed(lane_i.x);

  // Stage A: register the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.vld <= 1'b0;
    end else begin
      mul_r.vld <= lane_i.vld;
    end
    mul_r.x   <= lane_i.x;
    mul_r.acc <= lane_i.acc;
    mul_r.ovf <= lane_i.ovf;
    prod_r    <= prod_nxt;
  end

  // Stage B: floor shift, saturate, add, saturate
  always_comb begin
    shifted = prod_r >>> FRAC_BITS;
    mul_sat = !((&shifted[PROD_W-1:DATA_W-1]) || !(|shifted[PROD_W-1:DATA_W-1]));
    if (mul_sat) begin
      term = shifted[PROD_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      term = shifted[DATA_W-1:0];
    end
    sum     = {term[DATA_W-1], term} + {coeff_i[DATA_W-1], coeff_i};
    add_sat = sum[DATA_W] != sum[DATA_W-1];

    out_nxt = mul_r;
    if (active_i) begin
      if (add_sat) begin
        out_nxt.acc = sum[DATA_W] ? SAT_MIN : SAT_MAX;
      end else begin
        out_nxt.acc = sum[DATA_W-1:0];
      end
      out_nxt.ovf = mul_r.ovf | mul_sat | add_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else begin
      out_r.vld <= out_nxt.vld;
    end
    out_r.x   <= out_nxt.x;
    out_r.acc <= out_nxt.acc;
    out_r.ovf <= out_nxt.ovf;
  end

  assign lane_o = out_r;

endmodule

`default_nettype wire

// ----- design/polynomial_evaluator.sv -----
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Pipelined Horner evaluator of a signed Q16.16 polynomial of degree 0 to 6.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write the degree (index 0) and coeff_0..coeff_6 (indexes
//   1..7) on the cfg_ channel; a transaction completes when cfg_valid and
//   cfg_ready are high (cfg_ready is always high). Degrees above 6 act as 6,
//   other indexes are ignored. Write only while no evaluation is in flight.
//   Input: a transaction is taken when start is high and busy is low. busy
//   stays low, so a new point may enter on every clock cycle.
//   Output: each point gives one result, shown for one cycle with out_valid,
//   once its transaction has passed through one entry register, then six
//   Horner steps of two registers each (multiply, then shift/saturate/add).
//   Every step is present for every degree; steps at or above the degree pass
//   the accumulator through unchanged, which keeps the latency fixed.
//   Throughput: one point per cycle, set by the fully unrolled step chain.
//   The receiver cannot stall, so nothing is held back.
//   Reset (rst_n low, synchronous): clear the valid bits and the configuration
//   registers, and drop every evaluation in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_evaluator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [poly_pkg::DATA_W-1:0]    in_point_x,
  // result channel
  output logic                                out_valid,
  output logic [poly_pkg::DATA_W-1:0]         out_poly_value,
  output logic                                out_overflowed,
  // configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [poly_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [poly_pkg::DATA_W-1:0]    cfg_data
);
  import poly_pkg::*;

  logic [DEG_W-1:0] degree;
  coeff_vec_t       coeffs;
  lane_t            entry_r;
  lane_t            lanes [MAX_DEGREE+1];

  poly_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .degree    (degree),
    .coeffs    (coeffs)
  );

  // The pipeline never refuses a point
  assign busy = 1'b0;

  // Entry stage: seed the accumulator with the top coefficient in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
    end else begin
      entry_r.vld <= start && !busy;
    end
    entry_r.x   <= in_point_x;
    entry_r.acc <= coeffs[COEFF_IDX_W'(degree)];
    entry_r.ovf <= 1'b0;
  end

  assign lanes[0] = entry_r;

  // Step j handles coefficient k = MAX_DEGREE-1-j; active only below degree
  for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
    localparam int K = MAX_DEGREE - 1 - j;

    poly_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .active_i (DEG_W'(K) < degree),
      .coeff_i  (coeffs[K]),
      .lane_i   (lanes[j]),
      .lane_o   (lanes[j+1])
    );
  end

  assign out_valid      = lanes[MAX_DEGREE].vld;
  assign out_poly_value = lanes[MAX_DEGREE].acc;
  assign out_overflowed = lanes[MAX_DEGREE].ovf;

endmodule

`default_nettype wire

// ----- design/poly_checker.sv -----
// ----------------------------------------------------------------------------
// poly_checker
// Port-level checks on reset flush and fixed latency of the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module poly_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);
  import poly_pkg::*;

  // Reset flushes the pipeline
  `ASSERT_CLK_ALWAYS(a_reset_flush, !rst_n |=> !out_valid, "result strobe right after reset")

  // Every accepted transaction yields a result after the fixed latency
  `ASSERT_CLK(a_result_follows, (start && !busy) |-> ##LATENCY out_valid, "result missing")

  // No result without a transaction the fixed latency earlier
  `ASSERT_CLK(a_no_phantom, out_valid |-> $past(start && !busy, LATENCY), "unexpected result")

endmodule

bind polynomial_evaluator poly_checker u_poly_checker (.*);

`default_nettype wire
